[design/ptc_pkg.sv]
package ptc_pkg;

  localparam int unsigned DivStages = 32;

  localparam logic [1:0] CFG_TEMP = 2'd0;
  localparam logic [1:0] CFG_PLO  = 2'd1;
  localparam logic [1:0] CFG_PHI  = 2'd2;
  localparam logic [1:0] CFG_P9   = 2'd3;

  typedef struct packed {
    logic [31:0] tc;
    logic [31:0] fine;
    logic [19:0] ap;
  } tside_t;

  // Values that travel with an item through the divider
  typedef struct packed {
    logic [31:0] tc;
    logic [31:0] fine;
    logic        ok;
    logic        hi;
  } dtag_t;

  function automatic logic [31:0] sra32(input logic [31:0] x, input int unsigned s);
    return 32'($signed(x) >>> s);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] h);
    return {{16{h[15]}}, h};
  endfunction

endpackage

[design/ptc_div.sv]
// Restoring unsigned divider, one quotient bit per stage, fully pipelined.
module ptc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_vld,
  input  logic [31:0]        in_num,
  input  logic [31:0]        in_den,
  input  ptc_pkg::dtag_t     in_tag,
  output logic               out_vld,
  output logic [31:0]        out_quo,
  output ptc_pkg::dtag_t     out_tag
);
  import ptc_pkg::*;

  logic [DivStages-1:0] vld_r;
  logic [31:0] num_r [DivStages];
  logic [31:0] rem_r [DivStages];
  logic [31:0] den_r [DivStages];
  dtag_t       tag_r [DivStages];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DivStages-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    logic [32:0] t;
    if (adv) begin
      for (int i = 0; i < DivStages; i++) begin
        if (i == 0) begin
          t = {32'd0, in_num[31]};
          den_r[0] <= in_den;
          tag_r[0] <= in_tag;
          if (t >= {1'b0, in_den}) begin
            rem_r[0] <= 32'(t - {1'b0, in_den});
            num_r[0] <= {in_num[30:0], 1'b1};
          end else begin
            rem_r[0] <= t[31:0];
            num_r[0] <= {in_num[30:0], 1'b0};
          end
        end else begin
          t = {rem_r[i-1], num_r[i-1][31]};
          den_r[i] <= den_r[i-1];
          tag_r[i] <= tag_r[i-1];
          if (t >= {1'b0, den_r[i-1]}) begin
            rem_r[i] <= 32'(t - {1'b0, den_r[i-1]});
            num_r[i] <= {num_r[i-1][30:0], 1'b1};
          end else begin
            rem_r[i] <= t[31:0];
            num_r[i] <= {num_r[i-1][30:0], 1'b0};
          end
        end
      end
    end
  end

  assign out_vld = vld_r[DivStages-1];
  assign out_quo = num_r[DivStages-1];
  assign out_tag = tag_r[DivStages-1];
endmodule

[design/pressure_temp_compensation.sv]
// Barometric compensation pipeline.
// Input channel: in_valid/in_stall with raw_temperature and raw_pressure.
// Result channel: out_valid/out_stall with temperature_centi, fine_temperature,
// pressure_pa and pressure_valid; one result for every input, in order.
// Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data, always ready;
// write only while the pipeline is empty.
// From accept to result: 12 front stages, the 32-stage
// restoring divider (one quotient bit per stage) and the back stages.
// Throughput: one item per cycle while no stall holds the pipeline.
// Every stage advances together whenever the output register is empty or
// taken; a stall on out_stall freezes the whole pipeline and in_stall is
// raised so no request is lost or repeated.
// A zero divisor gives pressure 0 with pressure_valid low.
// Reset clears all stage valid bits and the coefficients to zero.
module pressure_temp_compensation (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [19:0]  in_raw_temperature,
  input  logic [19:0]  in_raw_pressure,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [31:0]  out_temperature_centi,
  output logic [31:0]  out_fine_temperature,
  output logic [31:0]  out_pressure_pa,
  output logic         out_pressure_valid,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_data
);
  import ptc_pkg::*;

  logic [47:0] tco_r;
  logic [63:0] plo_r, phi_r;
  logic [15:0] p9_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tco_r <= '0; plo_r <= '0; phi_r <= '0; p9_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TEMP: tco_r <= cfg_data[47:0];
        CFG_PLO:  plo_r <= cfg_data;
        CFG_PHI:  phi_r <= cfg_data;
        CFG_P9:   p9_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = {16'd0, tco_r[15:0]};
  assign t2 = sx16(tco_r[31:16]);
  assign t3 = sx16(tco_r[47:32]);
  assign p1 = {16'd0, plo_r[15:0]};
  assign p2 = sx16(plo_r[31:16]);
  assign p3 = sx16(plo_r[47:32]);
  assign p4 = sx16(plo_r[63:48]);
  assign p5 = sx16(phi_r[15:0]);
  assign p6 = sx16(phi_r[31:16]);
  assign p7 = sx16(phi_r[47:32]);
  assign p8 = sx16(phi_r[63:48]);
  assign p9 = sx16(p9_r);

  logic adv;
  assign adv = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Front stages A..L, each with a valid bit
  localparam int NF = 12;
  logic [NF-1:0] v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[NF-2:0], in_valid};
  end

  // stage 0: temperature differences
  logic [31:0] s0_e_r, s0_d_r; logic [19:0] s0_ap_r;
  // stage 1: products
  logic [31:0] s1_a_r, s1_dd_r; logic [19:0] s1_ap_r;
  // stage 2
  logic [31:0] s2_a_r, s2_b_r; logic [19:0] s2_ap_r;
  // stage 3: fine
  logic [31:0] s3_f_r; logic [19:0] s3_ap_r;
  // stage 4: tc product, x, q
  logic [31:0] s4_f_r, s4_tc_r, s4_x_r, s4_q_r; logic [19:0] s4_ap_r;
  tside_t s5_t_r, s6_t_r, s7_t_r, s8_t_r, s9_t_r, s10_t_r, s11_t_r;
  // stage 5: q*q, x*p5, p2*x
  logic [31:0] s5_qq_r, s5_xp5_r, s5_p2x_r;
  // stage 6
  logic [31:0] s6_a6_r, s6_q13_r, s6_xp5_r, s6_p2x_r;
  // stage 7
  logic [31:0] s7_a_r, s7_b3_r, s7_p2x_r;
  // stage 8
  logic [31:0] s8_a_r, s8_b_r;
  // stage 9
  logic [31:0] s9_a_r, s9_bb_r;
  // stage 10: divisor b, numerator base
  logic [31:0] s10_b_r, s10_n_r;
  // stage 11: times 3125
  logic [31:0] s11_b_r, s11_n_r;

  always_ff @(posedge clk) begin
    logic [31:0] tmp;
    if (adv) begin
      s0_e_r  <= 32'({12'd0, in_raw_temperature[19:3]}) - (t1 << 1);
      s0_d_r  <= 32'({12'd0, in_raw_temperature[19:4]}) - t1;
      s0_ap_r <= in_raw_pressure;

      s1_a_r  <= sra32(32'(s0_e_r * t2), 11);
      s1_dd_r <= 32'(s0_d_r * s0_d_r);
      s1_ap_r <= s0_ap_r;

      s2_a_r  <= s1_a_r;
      s2_b_r  <= 32'(sra32(s1_dd_r, 12) * t3);
      s2_ap_r <= s1_ap_r;

      s3_f_r  <= s2_a_r + sra32(s2_b_r, 14);
      s3_ap_r <= s2_ap_r;

      tmp      = sra32(s3_f_r, 1) - 32'd64000;
      s4_f_r  <= s3_f_r;
      s4_tc_r <= sra32(32'(s3_f_r * 32'd5) + 32'd128, 8);
      s4_x_r  <= tmp;
      s4_q_r  <= sra32(tmp, 2);
      s4_ap_r <= s3_ap_r;

      s5_t_r   <= '{tc: s4_tc_r, fine: s4_f_r, ap: s4_ap_r};
      s5_qq_r  <= 32'(s4_q_r * s4_q_r);
      s5_xp5_r <= 32'(s4_x_r * p5);
      s5_p2x_r <= 32'(p2 * s4_x_r);

      s6_t_r   <= s5_t_r;
      s6_a6_r  <= 32'(sra32(s5_qq_r, 11) * p6);
      s6_q13_r <= sra32(s5_qq_r, 13);
      s6_xp5_r <= s5_xp5_r << 1;
      s6_p2x_r <= sra32(s5_p2x_r, 1);

      s7_t_r   <= s6_t_r;
      s7_a_r   <= sra32(s6_a6_r + s6_xp5_r, 2) + (p4 << 16);
      s7_b3_r  <= sra32(32'(p3 * s6_q13_r), 3);
      s7_p2x_r <= s6_p2x_r;

      s8_t_r <= s7_t_r;
      s8_a_r <= s7_a_r;
      s8_b_r <= sra32(s7_b3_r + s7_p2x_r, 18);

      s9_t_r  <= s8_t_r;
      s9_a_r  <= s8_a_r;
      s9_bb_r <= 32'((32'd32768 + s8_b_r) * p1);

      s10_t_r <= s9_t_r;
      s10_b_r <= sra32(s9_bb_r, 15);
      s10_n_r <= (32'd1048576 - {12'd0, s9_t_r.ap}) - sra32(s9_a_r, 12);

      s11_t_r <= s10_t_r;
      s11_b_r <= s10_b_r;
      s11_n_r <= 32'(s10_n_r * 32'd3125);
    end
  end

  // Divider
  dtag_t dtag;
  logic [31:0] dnum, dden;
  assign dtag = '{tc: s11_t_r.tc, fine: s11_t_r.fine, ok: (s11_b_r != 32'd0),
                  hi: s11_n_r[31]};
  assign dnum = s11_n_r[31] ? s11_n_r : (s11_n_r << 1);
  assign dden = (s11_b_r == 32'd0) ? 32'd1 : s11_b_r;

  logic d_vld; logic [31:0] d_quo; dtag_t d_tag;
  ptc_div u_div (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_vld(v_r[NF-1]),
    .in_num(dnum), .in_den(dden), .in_tag(dtag),
    .out_vld(d_vld), .out_quo(d_quo), .out_tag(d_tag)
  );

  // Back stages
  logic [3:0] w_r;
  always_ff @(posedge clk) begin
    if (!rst_n) w_r <= '0;
    else if (adv) w_r <= {w_r[2:0], d_vld};
  end
  dtag_t b0_t_r, b1_t_r, b2_t_r;
  logic [31:0] b0_p_r, b1_p_r, b1_u_r, b1_v_r, b2_p_r, b2_u_r, b2_v_r;
  logic [31:0] o_tc_r, o_f_r, o_p_r; logic o_pv_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      b0_t_r <= d_tag;
      b0_p_r <= d_tag.hi ? (d_quo << 1) : d_quo;

      b1_t_r <= b0_t_r;
      b1_p_r <= b0_p_r;
      b1_u_r <= 32'({3'd0, b0_p_r[31:3]} * {3'd0, b0_p_r[31:3]});
      b1_v_r <= 32'({2'd0, b0_p_r[31:2]} * p8);

      b2_t_r <= b1_t_r;
      b2_p_r <= b1_p_r;
      b2_u_r <= 32'(p9 * (b1_u_r >> 13));
      b2_v_r <= sra32(b1_v_r, 13);

      o_tc_r <= b2_t_r.tc;
      o_f_r  <= b2_t_r.fine;
      o_pv_r <= b2_t_r.ok;
      o_p_r  <= b2_t_r.ok ?
                b2_p_r + sra32(sra32(b2_u_r, 12) + b2_v_r + p7, 4) : 32'd0;
    end
  end

  assign out_valid             = w_r[3];
  assign out_temperature_centi = o_tc_r;
  assign out_fine_temperature  = o_f_r;
  assign out_pressure_pa       = o_p_r;
  assign out_pressure_valid    = o_pv_r;
endmodule
